### hw/rtl/radar_spoke_blob_segmenter_top_macros.svh
// Assertion macros used by the segmenter checker file.
`ifndef RADAR_SPOKE_BLOB_SEGMENTER_TOP_MACROS_SVH
`define RADAR_SPOKE_BLOB_SEGMENTER_TOP_MACROS_SVH

// Clocked property, off while reset is high.
`define RSBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen.
`define RSBS_NEVER(label, expr, msg) \
  `RSBS_ASSERT(label, !(expr), msg)

`endif

### hw/rtl/rsbs_pkg.sv
// Types and constants of the radar spoke segmenter.
package rsbs_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = 8;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;
  localparam int unsigned ALPHA_FULL  = 255;
  localparam int unsigned PADDR_W     = 3;

  // Register index as decoded from paddr[2].
  localparam logic REG_SPOKES_PER_TURN = 1'b0;
  localparam logic REG_TRANSPARENCY    = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [12:0] SPT_RESET = 13'd2048;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  strength;
    logic [3:0]  class_value;
    logic [11:0] spoke_index;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [11:0] seg_spoke;
    logic [9:0]  seg_begin;
    logic [10:0] seg_end;
    logic [3:0]  seg_class;
    logic [7:0]  seg_alpha;
    logic        last_of_spoke;
  } seg_item_t;

  // Results pushed into the output queue in one cycle.
  typedef struct packed {
    logic first_vld;
    logic second_vld;
  } push_t;

endpackage

### hw/rtl/radar_spoke_blob_segmenter_top.sv
// Top level of the radar spoke run segmenter.
// A sample's segments are registered in the input stage (s1, class-memory read)
// and then in the output queue before out_valid; a second segment follows.
// Throughput: one item per cycle; a sample may yield two segments, which the
// 4-entry output queue absorbs; in_stall rises only when that queue lacks room.
// Reset (rst, synchronous): run state, queue and class table cleared to none.
module radar_spoke_blob_segmenter_top #(
  parameter int unsigned MAX_SPOKE_LEN    = 1024,
  parameter int unsigned MAX_TRANSPARENCY = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rsbs_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rsbs_pkg::seg_item_t            out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsbs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned RC_W = $clog2(MAX_SPOKE_LEN + 1);
  localparam int unsigned RS_W = $clog2(MAX_SPOKE_LEN);

  function automatic logic [7:0] alpha_calc(input int t);
    int tc;
    tc = (t > int'(MAX_TRANSPARENCY)) ? int'(MAX_TRANSPARENCY) : t;
    return 8'((int'(rsbs_pkg::ALPHA_FULL) * (int'(MAX_TRANSPARENCY) - tc))
              / MAX_TRANSPARENCY);
  endfunction

  // configuration
  logic [12:0] spokes_per_turn;
  logic [3:0]  transparency;
  logic [7:0]  alpha;
  logic [7:0]  alpha_lut [16];
  logic        cfg_wr;

  for (genvar g = 0; g < 16; g++) begin : g_alpha
    assign alpha_lut[g] = alpha_calc(g);
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spokes_per_turn <= rsbs_pkg::SPT_RESET;
      transparency    <= 4'd0;
      alpha           <= alpha_lut[0];
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rsbs_pkg::REG_SPOKES_PER_TURN: spokes_per_turn <= pwdata[12:0];
        rsbs_pkg::REG_TRANSPARENCY: begin
          transparency <= pwdata[3:0];
          alpha        <= alpha_lut[pwdata[3:0]];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rsbs_pkg::REG_SPOKES_PER_TURN: prdata = {19'd0, spokes_per_turn};
      rsbs_pkg::REG_TRANSPARENCY:    prdata = {28'd0, transparency};
      default:                       prdata = '0;
    endcase
  end

  // input stage
  logic                       in_acc;
  logic                       s1_vld;
  logic [11:0]                s1_spoke;
  logic                       s1_last;
  logic                       s1_fire;
  logic [3:0]                 s1_class;
  logic [rsbs_pkg::FIFO_AW:0] q_count;

  assign s1_fire  = s1_vld && (q_count <= (rsbs_pkg::FIFO_AW+1)'(rsbs_pkg::FIFO_DEPTH - 2));
  assign in_stall = s1_vld && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  rsbs_class_mem u_class_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc && (in_item.cmd == rsbs_pkg::CMD_LOAD)),
    .wr_addr  (in_item.strength),
    .wr_data  (in_item.class_value),
    .rd_en    (in_acc && (in_item.cmd == rsbs_pkg::CMD_SAMPLE)),
    .rd_addr  (in_item.strength),
    .rd_class (s1_class)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_acc) begin
      s1_vld <= (in_item.cmd == rsbs_pkg::CMD_SAMPLE);
    end else if (s1_fire) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_spoke <= in_item.spoke_index;
      s1_last  <= in_item.last_sample;
    end
  end

  // run tracking
  logic [3:0]      open_class, open_class_next, open_mid;
  logic [RS_W-1:0] run_start, run_start_next, start_mid;
  logic [RC_W-1:0] run_stop, run_stop_next, stop_mid;
  logic [RC_W-1:0] radius_count, radius_count_next;
  logic            drop, active;
  rsbs_pkg::push_t      push;
  rsbs_pkg::seg_item_t  seg_a, seg_b;

  always_comb begin
    drop              = ({1'b0, s1_spoke} >= spokes_per_turn);
    active            = (radius_count < RC_W'(MAX_SPOKE_LEN));
    open_mid          = open_class;
    start_mid         = run_start;
    stop_mid          = run_stop;
    radius_count_next = radius_count;
    push              = '0;

    seg_a.seg_spoke     = s1_spoke;
    seg_a.seg_begin     = 10'(run_start);
    seg_a.seg_end       = 11'(run_stop);
    seg_a.seg_class     = open_class;
    seg_a.seg_alpha     = alpha;
    seg_a.last_of_spoke = 1'b0;

    if (drop) begin
      if (s1_last) begin
        open_mid          = 4'd0;
        radius_count_next = '0;
      end
    end else if (active) begin
      if (s1_class == open_class) begin
        if (s1_class != 4'd0) begin
          stop_mid = radius_count + RC_W'(1);
        end
      end else begin
        push.first_vld = (open_class != 4'd0);
        if (s1_class != 4'd0) begin
          start_mid = RS_W'(radius_count);
          stop_mid  = radius_count + RC_W'(1);
        end
        open_mid = s1_class;
      end
      radius_count_next = radius_count + RC_W'(1);
    end

    seg_b.seg_spoke     = s1_spoke;
    seg_b.seg_begin     = 10'(start_mid);
    seg_b.seg_end       = 11'(stop_mid);
    seg_b.seg_class     = open_mid;
    seg_b.seg_alpha     = alpha;
    seg_b.last_of_spoke = 1'b1;

    open_class_next = open_mid;
    run_start_next  = start_mid;
    run_stop_next   = stop_mid;
    if (s1_last && !drop) begin
      push.second_vld     = (open_mid != 4'd0);
      // with no closing segment the class-change segment ends the spoke
      seg_a.last_of_spoke = (open_mid == 4'd0);
      open_class_next     = 4'd0;
      radius_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_class   <= 4'd0;
      run_start    <= '0;
      run_stop     <= '0;
      radius_count <= '0;
    end else if (s1_fire) begin
      open_class   <= open_class_next;
      run_start    <= run_start_next;
      run_stop     <= run_stop_next;
      radius_count <= radius_count_next;
    end
  end

  rsbs_seg_fifo u_seg_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (s1_fire ? push : '0),
    .first_item  (seg_a),
    .second_item (seg_b),
    .count       (q_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

### hw/rtl/rsbs_class_mem.sv
// Class lookup memory with per-entry valid bits; unwritten entries read as none.
module rsbs_class_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rsbs_pkg::TABLE_AW-1:0]  wr_addr,
  input  logic [3:0]                     wr_data,
  input  logic                           rd_en,
  input  logic [rsbs_pkg::TABLE_AW-1:0]  rd_addr,
  output logic [3:0]                     rd_class
);

  logic [3:0]                       mem [rsbs_pkg::TABLE_DEPTH];
  logic [rsbs_pkg::TABLE_DEPTH-1:0] entry_vld;
  logic [3:0]                       rd_data;
  logic                             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= entry_vld[rd_addr];
      end
    end
  end

  assign rd_class = rd_vld ? rd_data : 4'd0;

endmodule

### hw/rtl/rsbs_seg_fifo.sv
// Segment queue; takes up to two per cycle, gives one unless out_stall.
module rsbs_seg_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  rsbs_pkg::push_t              push,
  input  rsbs_pkg::seg_item_t          first_item,
  input  rsbs_pkg::seg_item_t          second_item,
  output logic [rsbs_pkg::FIFO_AW:0]   count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rsbs_pkg::seg_item_t          out_item
);

  rsbs_pkg::seg_item_t           slots [rsbs_pkg::FIFO_DEPTH];
  logic [rsbs_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [rsbs_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [rsbs_pkg::FIFO_AW-1:0]  wr_ptr_2nd;
  logic [rsbs_pkg::FIFO_AW:0]    push_n;
  logic                          pop;

  assign out_valid  = (count != '0);
  assign out_item   = slots[rd_ptr];
  assign pop        = out_valid && !out_stall;
  assign wr_ptr_2nd = wr_ptr + rsbs_pkg::FIFO_AW'(1);
  assign push_n     = (rsbs_pkg::FIFO_AW+1)'(push.first_vld) +
                      (rsbs_pkg::FIFO_AW+1)'(push.second_vld);

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      slots[wr_ptr] <= first_item;
      if (push.second_vld) begin
        slots[wr_ptr_2nd] <= second_item;
      end
    end else if (push.second_vld) begin
      slots[wr_ptr] <= second_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[rsbs_pkg::FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + rsbs_pkg::FIFO_AW'(1);
      end
      count <= count + push_n - (rsbs_pkg::FIFO_AW+1)'(pop);
    end
  end

endmodule

### hw/rtl/rsbs_checker.sv
// Port-level checks for the segmenter, bound to the top level.
`include "radar_spoke_blob_segmenter_top_macros.svh"

module rsbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input rsbs_pkg::seg_item_t           out_item
);

  logic out_held;

  assign out_held = out_valid && out_stall;

  `RSBS_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_item), "stalled item changed")

  `RSBS_NEVER(a_class_none, out_valid && (out_item.seg_class == 4'd0), "segment with class none")

  `RSBS_ASSERT(a_reset_empty, $past(rst) |-> !out_valid, "segment right after reset")

endmodule

bind radar_spoke_blob_segmenter_top rsbs_checker u_rsbs_checker (.*);
